>>> rtl/lfia_pkg.sv
// Shared constants, codes and controller/datapath types for the identifier allocator.
package lfia_pkg;

  localparam int MAX_IDS   = 256;
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = MAX_IDS / WORD_W;
  localparam int WIDX_W    = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int IDX_W     = WIDX_W + BIT_W;
  localparam int ID_W      = 9;
  localparam int STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ASSIGNED = 2'd2;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic capture;
    logic scan_clear;
    logic scan_step;
    logic commit_alloc;
    logic commit_exh;
    logic commit_rel;
    logic load_out;
  } lfia_cmd_t;

  typedef struct packed {
    logic word_has_free;
    logic last_word;
  } lfia_sts_t;

endpackage

>>> rtl/lfia_ctrl.sv
// Controller state machine: sequences capture, bitmap scan, release and result hand-off.
module lfia_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  lfia_pkg::lfia_sts_t sts,
  output lfia_pkg::lfia_cmd_t cmd
);
  import lfia_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_REL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture    = 1'b1;
          cmd.scan_clear = 1'b1;
          state_nxt      = (in_kind == KIND_RELEASE) ? S_REL : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.word_has_free) begin
          cmd.commit_alloc = 1'b1;
          state_nxt        = S_DONE;
        end else if (sts.last_word) begin
          cmd.commit_exh = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_REL: begin
        cmd.commit_rel = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/lfia_datapath.sv
// Datapath: assigned-id bitmap, high-water mark, word scanner and result registers.
module lfia_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lfia_pkg::lfia_cmd_t             cmd,
  output lfia_pkg::lfia_sts_t             sts,
  input  logic                            in_kind,
  input  logic [lfia_pkg::ID_W-1:0]       in_release_id,
  output logic [lfia_pkg::ID_W-1:0]       out_granted_id,
  output logic [lfia_pkg::STATUS_W-1:0]   out_status
);
  import lfia_pkg::*;

  logic [WORD_W-1:0]   map_r [NUM_WORDS];
  logic [ID_W-1:0]     hwm_r;
  logic                kind_r;
  logic [ID_W-1:0]     rel_id_r;
  logic [WIDX_W-1:0]   widx_r;
  logic [ID_W-1:0]     res_id_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [ID_W-1:0]     rel_m1;
  logic [IDX_W-1:0]    rel_idx;
  logic [WIDX_W-1:0]   rd_addr;
  logic [WORD_W-1:0]   rd_word;
  logic [WORD_W-1:0]   free_mask;
  logic [BIT_W-1:0]    free_pos;
  logic [ID_W-1:0]     grant;
  logic                rel_ok;

  assign rel_m1  = rel_id_r - ID_W'(1);
  assign rel_idx = rel_m1[IDX_W-1:0];
  // one read port: release addresses its own word, allocate walks the words
  assign rd_addr = (kind_r == KIND_RELEASE) ? rel_idx[IDX_W-1:BIT_W] : widx_r;
  assign rd_word = map_r[rd_addr];
  assign free_mask = ~rd_word;

  always_comb begin
    free_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_mask[b]) free_pos = BIT_W'(b);
    end
  end

  assign grant  = ID_W'({widx_r, free_pos}) + ID_W'(1);
  assign rel_ok = (rel_id_r != '0) && (rel_id_r <= ID_W'(MAX_IDS)) &&
                  (rel_id_r <= hwm_r) && rd_word[rel_idx[BIT_W-1:0]];

  assign sts.word_has_free = |free_mask;
  assign sts.last_word     = (widx_r == WIDX_W'(NUM_WORDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WORDS; w++) map_r[w] <= '0;
      hwm_r  <= '0;
      widx_r <= '0;
    end else begin
      if (cmd.scan_clear) widx_r <= '0;
      else if (cmd.scan_step) widx_r <= widx_r + WIDX_W'(1);
      if (cmd.commit_alloc) begin
        map_r[widx_r][free_pos] <= 1'b1;
        if (grant > hwm_r) hwm_r <= grant;
      end
      if (cmd.commit_rel && rel_ok) map_r[rd_addr][rel_idx[BIT_W-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      rel_id_r <= in_release_id;
    end
    if (cmd.commit_alloc) begin
      res_id_r     <= grant;
      res_status_r <= STATUS_OK;
    end
    if (cmd.commit_exh) begin
      res_id_r     <= '0;
      res_status_r <= STATUS_EXHAUSTED;
    end
    if (cmd.commit_rel) begin
      res_id_r     <= '0;
      res_status_r <= rel_ok ? STATUS_OK : STATUS_NOT_ASSIGNED;
    end
    if (cmd.load_out) begin
      out_id_r     <= res_id_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_granted_id = out_id_r;
  assign out_status     = out_status_r;

endmodule

>>> rtl/lowest_free_id_allocator.sv
// Top level of the lowest-free identifier allocator: controller plus datapath.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | in_kind, in_release_id
//   out     | output    | out_valid / out_ready   | out_granted_id, out_status
//
// Allocate: scans the bitmap one 32-bit word per cycle, up to 8 words, then hands the
// result to the output register; release checks and, if assigned, clears its bit, then hands it on.
// A new item is taken once the previous one has reached the output register.
// Synchronous active-low reset clears the bitmap, high-water mark and control state.
// A stalled output holds its item; the finished next result waits until it is taken.
module lowest_free_id_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [lfia_pkg::ID_W-1:0]     in_release_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfia_pkg::ID_W-1:0]     out_granted_id,
  output logic [lfia_pkg::STATUS_W-1:0] out_status
);
  import lfia_pkg::*;

  lfia_cmd_t cmd;
  lfia_sts_t sts;

  lfia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfia_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_release_id  (in_release_id),
    .out_granted_id (out_granted_id),
    .out_status     (out_status)
  );

endmodule
